// File: rtl/core/iat_pkg.sv
// Incremental angle tracker: shared widths, register indexes and the CORDIC
// arctangent table. No dependencies.
package iat_pkg;

   localparam int RAW_W       = 16;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CAL_W       = 20;
   localparam int PROD_W      = 41;
   localparam int MUL_A_W     = 42;
   localparam int MUL_B_W     = 20;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W   = $clog2(MUL_B_W);
   localparam int CORD_W      = 44;
   localparam int Z_W         = 26;
   localparam int ANGLE_W     = 40;
   localparam int CORDIC_STEPS = 16;
   localparam int CORD_I_W    = $clog2(CORDIC_STEPS);
   localparam logic signed [Z_W-1:0] DEG90 = Z_W'(5898240);

   localparam logic [CSR_IDX_W-1:0] REG_X_OFFSET   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_OFFSET   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_SCALE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_SCALE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_GAIN = 3'd4;

   // round(atan(2^-i) * 65536) in degrees
   function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:  v = Z_W'(2949120);
         5'd1:  v = Z_W'(1740967);
         5'd2:  v = Z_W'(919879);
         5'd3:  v = Z_W'(466945);
         5'd4:  v = Z_W'(234379);
         5'd5:  v = Z_W'(117304);
         5'd6:  v = Z_W'(58666);
         5'd7:  v = Z_W'(29335);
         5'd8:  v = Z_W'(14668);
         5'd9:  v = Z_W'(7334);
         5'd10: v = Z_W'(3667);
         5'd11: v = Z_W'(1833);
         5'd12: v = Z_W'(917);
         5'd13: v = Z_W'(458);
         5'd14: v = Z_W'(229);
         5'd15: v = Z_W'(115);
         5'd16: v = Z_W'(57);
         5'd17: v = Z_W'(29);
         5'd18: v = Z_W'(14);
         5'd19: v = Z_W'(7);
         5'd20: v = Z_W'(4);
         5'd21: v = Z_W'(2);
         5'd22: v = Z_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/iat_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, over all MUL_B_W bits of b.
// Depends on iat_pkg.
module iat_mul import iat_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [MUL_A_W-1:0] a,
   input  logic signed [MUL_B_W-1:0] b,
   output logic                      done,
   output logic signed [MUL_P_W-1:0] product
);

   logic                      busy_ff;
   logic                      done_ff;
   logic [MUL_CNT_W-1:0]      cnt_ff;
   logic signed [MUL_P_W-1:0] acc_ff;
   logic signed [MUL_P_W-1:0] a_ff;
   logic [MUL_B_W-1:0]        b_ff;
   logic                      last;

   assign last    = (cnt_ff == MUL_CNT_W'(MUL_B_W - 1));
   assign done    = done_ff;
   assign product = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            acc_ff  <= '0;
            a_ff    <= {{(MUL_P_W-MUL_A_W){a[MUL_A_W-1]}}, a};
            b_ff    <= b;
         end else if (busy_ff) begin
            // sign bit of b carries negative weight
            if (b_ff[0]) begin
               if (last) begin
                  acc_ff <= acc_ff - a_ff;
               end else begin
                  acc_ff <= acc_ff + a_ff;
               end
            end
            a_ff   <= a_ff <<< 1;
            b_ff   <= b_ff >> 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// File: rtl/core/iat_cordic.sv
// Iterative vectoring CORDIC: atan2(y, x) in degrees signed Q10.16, one step per cycle.
// Depends on iat_pkg.
module iat_cordic import iat_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [PROD_W-1:0] x_in,
   input  logic signed [PROD_W-1:0] y_in,
   output logic                     done,
   output logic signed [Z_W-1:0]    z
);

   logic                     busy_ff;
   logic                     done_ff;
   logic [CORD_I_W-1:0]      i_ff;
   logic signed [CORD_W-1:0] x_ff;
   logic signed [CORD_W-1:0] y_ff;
   logic signed [Z_W-1:0]    z_ff;
   logic signed [CORD_W-1:0] xe;
   logic signed [CORD_W-1:0] ye;
   logic signed [CORD_W-1:0] xs;
   logic signed [CORD_W-1:0] ys;
   logic signed [Z_W-1:0]    step;
   logic                     last;

   assign xe   = {{(CORD_W-PROD_W){x_in[PROD_W-1]}}, x_in};
   assign ye   = {{(CORD_W-PROD_W){y_in[PROD_W-1]}}, y_in};
   assign xs   = x_ff >>> i_ff;
   assign ys   = y_ff >>> i_ff;
   assign step = atan_deg(5'(i_ff));
   assign last = (i_ff == CORD_I_W'(CORDIC_STEPS - 1));
   assign done = done_ff;
   assign z    = z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            i_ff <= '0;
            z_ff <= '0;
            if (x_in == '0 && y_in == '0) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               if (x_in[PROD_W-1] && !y_in[PROD_W-1]) begin
                  x_ff <= ye;
                  y_ff <= -xe;
                  z_ff <= DEG90;
               end else if (x_in[PROD_W-1]) begin
                  x_ff <= -ye;
                  y_ff <= xe;
                  z_ff <= -DEG90;
               end else begin
                  x_ff <= xe;
                  y_ff <= ye;
               end
            end
         end else if (busy_ff) begin
            if (!y_ff[CORD_W-1]) begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + step;
            end else begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - step;
            end
            i_ff <= i_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// File: rtl/core/incremental_angle_tracker.sv
// Incremental angle tracker top level: calibration, cross/dot, CORDIC, gain and
// saturating accumulator. Depends on iat_pkg, iat_mul and iat_cordic.
//
//   channel | ports                              | direction
//   req     | req_valid/ready, raw_x, raw_y      | in
//   rsp     | rsp_valid/ready, angle, seeded_only| out
//   csr     | csr_we, csr_index, csr_wdata       | in
//
// Each serial multiply runs to its done pulse before the state machine moves on.
// First item after reset: 2 multiplies, then the seeded result is registered.
// Later items: 7 multiplies plus one CORDIC run; the CORDIC skips its
// iterations when cross and dot are both zero.
// One item at a time; the next is taken once the result sits in the output
// register, which holds while rsp_ready is low.
// Reset is synchronous and restores registers, accumulator and seed flag.
module incremental_angle_tracker import iat_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [RAW_W-1:0]    req_raw_x,
   input  logic signed [RAW_W-1:0]    req_raw_y,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [ANGLE_W-1:0]  rsp_angle,
   output logic                       rsp_seeded_only,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_W-1:0]           csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_CALX, S_CALY, S_P1, S_P2, S_P3, S_P4, S_CORD, S_GAIN, S_FIN
   } state_type;

   state_type                 state_ff;
   logic [CSR_W-1:0]          x_off_ff, y_off_ff, x_scale_ff, y_scale_ff, gain_ff;
   logic signed [RAW_W-1:0]   raw_y_ff;
   logic signed [CAL_W-1:0]   calx_ff, caly_ff, prevx_ff, prevy_ff;
   logic signed [PROD_W-1:0]  cross_ff, dot_ff;
   logic signed [ANGLE_W-1:0] sum_ff;
   logic                      first_ff;
   logic                      seed_ff;
   logic                      mul_start_ff;
   logic signed [MUL_A_W-1:0] mul_a_ff;
   logic signed [MUL_B_W-1:0] mul_b_ff;
   logic                      cord_start_ff;
   logic signed [PROD_W-1:0]  cord_x_ff, cord_y_ff;
   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] rsp_angle_ff;
   logic                      rsp_seeded_ff;

   logic                      mul_done;
   logic signed [MUL_P_W-1:0] mul_p;
   logic                      cord_done;
   logic signed [Z_W-1:0]     cord_z;
   logic signed [MUL_P_W-1:0] rnd14, rnd15;
   logic signed [CAL_W-1:0]   cal_now;
   logic signed [PROD_W-1:0]  p_now;
   logic signed [ANGLE_W:0]   sum_in;
   logic signed [ANGLE_W-1:0] sat_in;
   logic signed [MUL_A_W-1:0] off_sum_y;

   iat_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (mul_a_ff),
      .b       (mul_b_ff),
      .done    (mul_done),
      .product (mul_p)
   );

   iat_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start_ff),
      .x_in  (cord_x_ff),
      .y_in  (cord_y_ff),
      .done  (cord_done),
      .z     (cord_z)
   );

   assign rnd14   = mul_p + MUL_P_W'(8192);
   assign rnd15   = mul_p + MUL_P_W'(16384);
   assign cal_now = rnd14[CAL_W+13:14];
   assign p_now   = mul_p[PROD_W-1:0];
   assign sum_in  = {sum_ff[ANGLE_W-1], sum_ff}
                  + {{(ANGLE_W+1-28){rnd15[42]}}, rnd15[42:15]};
   assign sat_in  = (sum_in[ANGLE_W] == sum_in[ANGLE_W-1]) ? sum_in[ANGLE_W-1:0] :
                    (sum_in[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                     : {1'b0, {(ANGLE_W-1){1'b1}}});
   assign off_sum_y = MUL_A_W'(raw_y_ff) + MUL_A_W'($signed(y_off_ff));

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_angle       = rsp_angle_ff;
   assign rsp_seeded_only = rsp_seeded_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_off_ff   <= '0;
         y_off_ff   <= '0;
         x_scale_ff <= CSR_W'(16384);
         y_scale_ff <= CSR_W'(16384);
         gain_ff    <= CSR_W'(32768);
      end else if (csr_we) begin
         case (csr_index)
            REG_X_OFFSET:   x_off_ff   <= csr_wdata;
            REG_Y_OFFSET:   y_off_ff   <= csr_wdata;
            REG_X_SCALE:    x_scale_ff <= csr_wdata;
            REG_Y_SCALE:    y_scale_ff <= csr_wdata;
            REG_ANGLE_GAIN: gain_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         first_ff      <= 1'b1;
         prevx_ff      <= '0;
         prevy_ff      <= '0;
         sum_ff        <= '0;
         mul_start_ff  <= 1'b0;
         cord_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mul_start_ff  <= 1'b0;
         cord_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  raw_y_ff     <= req_raw_y;
                  mul_a_ff     <= MUL_A_W'(req_raw_x) + MUL_A_W'($signed(x_off_ff));
                  mul_b_ff     <= MUL_B_W'(x_scale_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_CALX;
               end
            end
            S_CALX: begin
               if (mul_done) begin
                  calx_ff      <= cal_now;
                  mul_a_ff     <= off_sum_y;
                  mul_b_ff     <= MUL_B_W'(y_scale_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_CALY;
               end
            end
            S_CALY: begin
               if (mul_done) begin
                  caly_ff <= cal_now;
                  if (first_ff) begin
                     first_ff <= 1'b0;
                     prevx_ff <= calx_ff;
                     prevy_ff <= cal_now;
                     seed_ff  <= 1'b1;
                     state_ff <= S_FIN;
                  end else begin
                     mul_a_ff     <= MUL_A_W'(prevx_ff);
                     mul_b_ff     <= cal_now;
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_P1;
                  end
               end
            end
            S_P1: begin
               if (mul_done) begin
                  cross_ff     <= p_now;
                  mul_a_ff     <= MUL_A_W'(prevy_ff);
                  mul_b_ff     <= calx_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_P2;
               end
            end
            S_P2: begin
               if (mul_done) begin
                  cross_ff     <= cross_ff - p_now;
                  mul_a_ff     <= MUL_A_W'(prevx_ff);
                  mul_b_ff     <= calx_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_P3;
               end
            end
            S_P3: begin
               if (mul_done) begin
                  dot_ff       <= p_now;
                  mul_a_ff     <= MUL_A_W'(prevy_ff);
                  mul_b_ff     <= caly_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_P4;
               end
            end
            S_P4: begin
               if (mul_done) begin
                  cord_x_ff     <= dot_ff + p_now;
                  cord_y_ff     <= cross_ff;
                  cord_start_ff <= 1'b1;
                  state_ff      <= S_CORD;
               end
            end
            S_CORD: begin
               if (cord_done) begin
                  mul_a_ff     <= MUL_A_W'(cord_z);
                  mul_b_ff     <= MUL_B_W'(gain_ff);
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_GAIN;
               end
            end
            S_GAIN: begin
               if (mul_done) begin
                  sum_ff   <= sat_in;
                  prevx_ff <= calx_ff;
                  prevy_ff <= caly_ff;
                  seed_ff  <= 1'b0;
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_angle_ff  <= seed_ff ? '0 : sum_ff;
                  rsp_seeded_ff <= seed_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/iat_checker.sv
// Port-level checks for the incremental angle tracker, bound to the top level.
// Depends on iat_pkg.
module iat_checker import iat_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [ANGLE_W-1:0] rsp_angle,
   input logic                      rsp_seeded_only
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle))
      else $error("result item dropped or changed while stalled");

   a_seed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seeded_only |-> rsp_angle == '0)
      else $error("seed item reports nonzero angle");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while previous item in flight");

   a_first_seed: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result item out of reset");

endmodule

bind incremental_angle_tracker iat_checker u_iat_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_angle       (rsp_angle),
   .rsp_seeded_only (rsp_seeded_only)
);

// File: tb/sv/incremental_angle_tracker_checker.sv
// Checker for the incremental angle tracker: watches the sample and result
// channels, predicts each accumulated angle and compares. Depends on iat_pkg.
`timescale 1ns / 100ps
module incremental_angle_tracker_checker import iat_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [RAW_W-1:0]   req_raw_x,
   input  logic signed [RAW_W-1:0]   req_raw_y,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [ANGLE_W-1:0] rsp_angle,
   input  logic                      rsp_seeded_only,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_W-1:0]          csr_wdata,
   output int                        fail_count,
   output int                        pending
);

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic                      seeded;
   } track_result_type;

   localparam longint SUM_HI = (64'sd1 <<< 39) - 1;
   localparam longint SUM_LO = -(64'sd1 <<< 39);

   logic signed [15:0] x_off, y_off;
   logic [15:0]        x_scl, y_scl, gain;
   longint             last_x, last_y, heading;
   bit                 first_pending;
   track_result_type   expected_angles[$];

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint calibrated(logic signed [15:0] raw, logic signed [15:0] off,
                                         logic [15:0] scl);
      longint s;
      s = longint'(raw) + longint'(off);
      return floor_shift(s * longint'({1'b0, scl}) + 8192, 14);
   endfunction

   function automatic longint atan_degrees(longint y, longint x);
      longint z, t, xs, ys;
      longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1, 0};
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 5898240;
         end else begin
            t = x; x = -y; y = t; z = -5898240;
         end
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += tbl[i];
         end else begin
            x -= ys; y += xs; z -= tbl[i];
         end
      end
      return z;
   endfunction

   task automatic track_sample(logic signed [15:0] rx, logic signed [15:0] ry);
      longint cx, cy, d, sum;
      track_result_type r;
      cx = calibrated(rx, x_off, x_scl);
      cy = calibrated(ry, y_off, y_scl);
      if (first_pending) begin
         first_pending = 0;
         r.angle = '0;
         r.seeded = 1'b1;
      end else begin
         d = atan_degrees(last_x * cy - last_y * cx, last_x * cx + last_y * cy);
         d = floor_shift(d * longint'({1'b0, gain}) + 16384, 15);
         sum = heading + d;
         if (sum > SUM_HI) sum = SUM_HI;
         if (sum < SUM_LO) sum = SUM_LO;
         heading = sum;
         r.angle = ANGLE_W'(heading);
         r.seeded = 1'b0;
      end
      last_x = cx;
      last_y = cy;
      expected_angles.push_back(r);
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      track_result_type e;
      if (reset) begin
         x_off <= '0; y_off <= '0;
         x_scl <= 16'd16384; y_scl <= 16'd16384; gain <= 16'd32768;
         last_x = 0; last_y = 0; heading = 0; first_pending = 1;
         expected_angles.delete();
      end else begin
         if (req_valid && req_ready) track_sample(req_raw_x, req_raw_y);
         if (rsp_valid && rsp_ready) begin
            if (expected_angles.size() == 0) begin
               report_mismatch("result with none expected");
            end else begin
               e = expected_angles.pop_front();
               if (rsp_angle !== e.angle)
                  report_mismatch($sformatf("angle %0d expected %0d", rsp_angle, e.angle));
               if (rsp_seeded_only !== e.seeded)
                  report_mismatch($sformatf("seeded_only %b expected %b",
                                            rsp_seeded_only, e.seeded));
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_X_OFFSET:   x_off <= csr_wdata;
               REG_Y_OFFSET:   y_off <= csr_wdata;
               REG_X_SCALE:    x_scl <= csr_wdata;
               REG_Y_SCALE:    y_scl <= csr_wdata;
               REG_ANGLE_GAIN: gain  <= csr_wdata;
               default: ;
            endcase
         end
      end
      pending = expected_angles.size();
   end

endmodule

// File: tb/sv/incremental_angle_tracker_tb.sv
// Testbench top for the incremental angle tracker: clock, reset, register
// writes and sample stimulus with random idling. Depends on iat_pkg, the tracker and the checker.
`timescale 1ns / 100ps
module incremental_angle_tracker_tb;
   import iat_pkg::*;

   logic                      clock = 0, reset = 1;
   logic                      req_valid = 0, req_ready;
   logic signed [RAW_W-1:0]   req_raw_x = '0, req_raw_y = '0;
   logic                      rsp_valid, rsp_ready = 0;
   logic signed [ANGLE_W-1:0] rsp_angle;
   logic                      rsp_seeded_only;
   logic                      csr_we = 0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_W-1:0]          csr_wdata = '0;
   int                        fail_count, pending;
   int                        send_idle = 31, recv_idle = 73;
   longint                    cycle = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   incremental_angle_tracker DUT (.*);

   incremental_angle_tracker_checker u_checker (.*);

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 64'd3000000) begin
         $display("incremental_angle_tracker regression: fail");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle);

   task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y);
      while ($urandom_range(99) < send_idle) @(posedge clock);
      req_valid <= 1;
      req_raw_x <= x;
      req_raw_y <= y;
      do @(posedge clock); while (!req_ready);
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic drain;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // rotate a vector of given radius through n random steps
   task automatic send_rotation(int n, real radius, real step_max);
      real a;
      a = $urandom_range(359) * 3.14159265 / 180.0;
      for (int i = 0; i < n; i++) begin
         a += (($urandom_range(2000) - 1000.0) / 1000.0) * step_max;
         send_sample(16'($rtoi(radius * $cos(a))), 16'($rtoi(radius * $sin(a))));
      end
   endtask

   task automatic random_phase(int n);
      for (int k = 0; k < n; k += 25) begin
         case ($urandom_range(3))
            0: send_rotation(25, 100.0 + $urandom_range(30000), 0.6);
            1: send_rotation(25, 20000.0, 3.1);
            2: send_rotation(25, 1.0 + $urandom_range(8), 1.5);
            default:
               for (int i = 0; i < 25; i++) send_sample(16'($urandom), 16'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_sample(16'sd1000, 16'sd0);
      send_sample(16'sd0, 16'sd1000);
      send_sample(-16'sd1000, 16'sd0);
      send_sample(16'sd0, -16'sd1000);
      send_sample(16'sd1000, 16'sd0);
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sh7fff, 16'sh7fff);
      send_sample(-16'sh8000, -16'sh8000);
      send_sample(16'sh7fff, -16'sh8000);
      send_sample(-16'sh8000, 16'sh7fff);
      send_sample(16'sd500, -16'sd1);
      send_sample(16'sd500, 16'sd1);
      drain();
      write_reg(REG_X_OFFSET, 16'h8000);
      write_reg(REG_Y_OFFSET, 16'h7fff);
      write_reg(REG_X_SCALE, 16'hffff);
      write_reg(REG_Y_SCALE, 16'h0000);
      write_reg(REG_ANGLE_GAIN, 16'hffff);
      write_reg(3'd7, 16'h1234);
      send_sample(16'sh7fff, -16'sh8000);
      send_sample(-16'sh8000, 16'sh7fff);
      send_sample(16'sd0, 16'sd0);
      drain();
      write_reg(REG_X_OFFSET, 16'h0000);
      write_reg(REG_Y_OFFSET, 16'h0000);
      write_reg(REG_X_SCALE, 16'hffff);
      write_reg(REG_Y_SCALE, 16'hffff);
      write_reg(REG_ANGLE_GAIN, 16'h0000);
      random_phase(100);
      drain();
      write_reg(REG_ANGLE_GAIN, 16'hffff);
      write_reg(REG_X_OFFSET, 16'($urandom_range(2000) - 1000));
      write_reg(REG_Y_OFFSET, 16'($urandom_range(2000) - 1000));
      write_reg(REG_X_SCALE, 16'($urandom_range(10000, 30000)));
      write_reg(REG_Y_SCALE, 16'($urandom_range(10000, 30000)));
      random_phase(250);
      drain();
      send_idle = 73;
      recv_idle = 31;
      write_reg(REG_X_OFFSET, 16'($urandom));
      write_reg(REG_Y_OFFSET, 16'($urandom));
      write_reg(REG_X_SCALE, 16'($urandom));
      write_reg(REG_Y_SCALE, 16'($urandom));
      write_reg(REG_ANGLE_GAIN, 16'($urandom));
      random_phase(200);
      drain();
      send_idle = 0;
      recv_idle = 0;
      write_reg(REG_X_OFFSET, 16'h0000);
      write_reg(REG_Y_OFFSET, 16'h0000);
      write_reg(REG_X_SCALE, 16'd16384);
      write_reg(REG_Y_SCALE, 16'd16384);
      write_reg(REG_ANGLE_GAIN, 16'd32768);
      random_phase(200);
      drain();
      if (fail_count == 0)
         $display("incremental_angle_tracker regression: pass");
      else
         $display("incremental_angle_tracker regression: fail");
      $finish;
   end

endmodule
